// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk, disabled in reset except ASSERT_NEXT_ALWAYS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// Types, character codes and stage functions of the C comment stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // Block comment stage mode.
    typedef enum logic [1:0] {
        BLK_NORMAL,
        BLK_SLASH,
        BLK_IN,
        BLK_STAR
    } blk_mode_t;

    // Line comment stage mode; the unused code behaves as normal text.
    typedef enum logic [1:0] {
        LN_NORMAL,
        LN_SLASH,
        LN_IN
    } ln_mode_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       run_last;
    } result_t;

    // One byte through the block stage: what it hands to the line stage.
    typedef struct packed {
        blk_mode_t mode;
        logic      pass_slash;   // release a held slash first
        logic      pass_char;    // then the byte itself
    } blk_step_t;

    // One byte through the line stage: what it emits.
    typedef struct packed {
        ln_mode_t mode;
        logic     emit_slash;    // held slash, before the byte
        logic     emit_char;     // the byte itself
    } ln_step_t;

    function automatic blk_step_t blk_step(blk_mode_t mode, logic [7:0] c);
        blk_step_t r;
        r.mode       = mode;
        r.pass_slash = 1'b0;
        r.pass_char  = 1'b0;
        unique case (mode)
            BLK_IN: begin
                if (c == CH_STAR) r.mode = BLK_STAR;
            end
            BLK_STAR: begin
                if (c == CH_SLASH)     r.mode = BLK_NORMAL;
                else if (c != CH_STAR) r.mode = BLK_IN;
            end
            BLK_SLASH: begin
                if (c == CH_STAR) begin
                    r.mode = BLK_IN;
                end else begin
                    r.pass_slash = 1'b1;
                    if (c == CH_SLASH) begin
                        r.mode = BLK_SLASH;
                    end else begin
                        r.mode      = BLK_NORMAL;
                        r.pass_char = 1'b1;
                    end
                end
            end
            default: begin
                if (c == CH_SLASH) begin
                    r.mode = BLK_SLASH;
                end else begin
                    r.mode      = BLK_NORMAL;
                    r.pass_char = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic ln_step_t ln_step(ln_mode_t mode, logic [7:0] c);
        ln_step_t r;
        r.mode       = mode;
        r.emit_slash = 1'b0;
        r.emit_char  = 1'b0;
        unique case (mode)
            LN_IN: begin
                // keep the line ending, leave the comment
                if (c == CH_CR || c == CH_LF) begin
                    r.emit_char = 1'b1;
                    r.mode      = LN_NORMAL;
                end
            end
            LN_SLASH: begin
                if (c == CH_SLASH) begin
                    r.mode = LN_IN;
                end else begin
                    r.emit_slash = 1'b1;
                    r.emit_char  = 1'b1;
                    r.mode       = LN_NORMAL;
                end
            end
            default: begin
                if (c == CH_SLASH) begin
                    r.mode = LN_SLASH;
                end else begin
                    r.emit_char = 1'b1;
                    r.mode      = LN_NORMAL;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/c_comment_stripper.sv =====
// ----------------------------------------------------------------------------
// c_comment_stripper
// Streaming removal of block and line comments from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Feed text one byte per transfer on the s_ channel; s_tlast marks the last
//   byte of a text. Kept bytes leave on the m_ channel, one per transfer, with
//   m_tuser high. At the end of a text the final result carries m_tlast; if
//   nothing is left to send at that point, a marker transfer with m_tuser low
//   and m_tdata zero carries m_tlast alone.
//   A byte accepted on s_ waits in the input register; its results then enter
//   the result queue, whose head entry is driven on m_.
//   Throughput: one input byte per cycle while each byte yields at most one
//   result and the receiver takes results; a byte that releases a held slash
//   plus itself yields two results and fills the two-entry result queue, so
//   the rate is set by the single output port (one result per cycle).
//   Reset (aresetn low at a clock edge) empties the input register and the
//   result queue and returns both stages to normal text.
//   When the receiver stalls, the head result holds on m_ and the input
//   register keeps taking bytes as long as the queue has room for their
//   results; otherwise s_tready drops until space frees up.
// ----------------------------------------------------------------------------
module c_comment_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    // input byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_in
    input  logic       s_tlast,    // end_of_text
    // kept byte stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] char_out
    output logic       m_tuser,    // [0] has_char
    output logic       m_tlast     // run_last
);
    import ccs_pkg::*;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Stage modes
    blk_mode_t  blk_mode_reg, blk_mode_next;
    ln_mode_t   ln_mode_reg, ln_mode_next;

    // Result queue, head in entry 0
    result_t    q_reg [2];
    result_t    q_next [2];
    logic [1:0] cnt_reg, cnt_next;

    // Step decode
    blk_step_t  bs;
    ln_step_t   ls;
    ln_step_t   ls_slash;
    ln_step_t   ls_flush;
    ln_mode_t   ln_after_slash;
    ln_mode_t   ln_after_char;
    ln_mode_t   ln_after_flush;
    logic       emit_pre, emit_char, emit_flush;
    logic       marker;
    logic [1:0] n_bytes;
    logic [1:0] n_res;
    result_t    res0, res1;

    // Flow control
    logic       pop;
    logic       proc;
    logic [1:0] cnt_after;
    logic [2:0] fill;

    // ------------------------------------------------------------------
    // Walk the registered byte through both stages
    // ------------------------------------------------------------------
    always_comb begin
        bs             = blk_step(blk_mode_reg, in_char_reg);
        ls_slash       = ln_step(ln_mode_reg, CH_SLASH);
        ln_after_slash = bs.pass_slash ? ls_slash.mode : ln_mode_reg;
        ls             = ln_step(ln_after_slash, in_char_reg);
        ln_after_char  = bs.pass_char ? ls.mode : ln_after_slash;
        // end of text: push a held block-stage slash into the line stage
        ls_flush       = ln_step(ln_after_char, CH_SLASH);
        ln_after_flush = (bs.mode == BLK_SLASH) ? ls_flush.mode : ln_after_char;
        emit_pre       = bs.pass_char & ls.emit_slash;
        emit_char      = bs.pass_char & ls.emit_char;
        emit_flush     = in_last_reg & (ln_after_flush == LN_SLASH);
    end

    // ------------------------------------------------------------------
    // Next stage modes
    // ------------------------------------------------------------------
    always_comb begin
        blk_mode_next = blk_mode_reg;
        ln_mode_next  = ln_mode_reg;
        if (proc) begin
            if (in_last_reg) begin
                blk_mode_next = BLK_NORMAL;
                ln_mode_next  = LN_NORMAL;
            end else begin
                blk_mode_next = bs.mode;
                ln_mode_next  = ln_after_char;
            end
        end
    end

    // ------------------------------------------------------------------
    // Results of this byte: at most two, in order
    // ------------------------------------------------------------------
    always_comb begin
        n_bytes = {1'b0, emit_pre} + {1'b0, emit_char} + {1'b0, emit_flush};
        marker  = in_last_reg & (n_bytes == 2'd0);
        n_res   = marker ? 2'd1 : n_bytes;

        res0.char_out = emit_pre   ? CH_SLASH :
                        emit_char  ? in_char_reg :
                        emit_flush ? CH_SLASH : CH_NONE;
        res0.has_char = ~marker;
        res0.run_last = in_last_reg & (n_res == 2'd1);

        res1.char_out = (emit_pre & emit_char) ? in_char_reg : CH_SLASH;
        res1.has_char = 1'b1;
        res1.run_last = in_last_reg;
    end

    // ------------------------------------------------------------------
    // Flow control: process when the queue has room for every result
    // ------------------------------------------------------------------
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign pop       = m_tvalid & m_tready;
    assign cnt_after = cnt_reg - {1'b0, pop};
    assign fill      = {1'b0, cnt_after} + {1'b0, n_res};
    assign proc      = in_valid_reg & (fill <= 3'd2);
    assign s_tready  = ~in_valid_reg | proc;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    // shift on pop, then append this byte's results behind what remains
    always_comb begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_after;
        if (proc) begin
            cnt_next = fill[1:0];
            if (cnt_after == 2'd0) begin
                q_next[0] = res0;
                if (n_res == 2'd2) q_next[1] = res1;
            end else if (cnt_after == 2'd1) begin
                q_next[1] = res0;
            end
        end
    end

    assign m_tdata = q_reg[0].char_out;
    assign m_tuser = q_reg[0].has_char;
    assign m_tlast = q_reg[0].run_last;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            blk_mode_reg <= BLK_NORMAL;
            ln_mode_reg  <= LN_NORMAL;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            blk_mode_reg <= blk_mode_next;
            ln_mode_reg  <= ln_mode_next;
        end
    end

    // payload: load on transfer, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

// ===== rtl/ccs_checker.sv =====
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level assertions for the C comment stripper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled result holds
    `ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // an end-only marker is always the last result and carries a zero byte
    `ASSERT_NOW(a_marker_end, m_tvalid && !m_tuser, m_tlast && m_tdata == 8'h00, "malformed end marker")

    // reset empties the result queue
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid, "result pending after reset")

    // input only backs up while results are waiting
    `ASSERT_NOW(a_stall_cause, s_tvalid && !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (.*);
